/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes and types for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam logic [1:0] StatusInvalid = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

/* rtl/core/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new entry, or takes the
// entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
  parameter int TAG_BITS  = 32,
  parameter int PRIO_BITS = 8
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic                 occupied_i,
  input  logic [TAG_BITS-1:0]  new_tag_i,
  input  logic [PRIO_BITS-1:0] new_prio_i,
  input  logic                 left_ins_i,
  input  logic [TAG_BITS-1:0]  left_tag_i,
  input  logic [PRIO_BITS-1:0] left_prio_i,
  input  logic [TAG_BITS-1:0]  right_tag_i,
  input  logic [PRIO_BITS-1:0] right_prio_i,
  output logic                 ins_o,
  output logic [TAG_BITS-1:0]  tag_o,
  output logic [PRIO_BITS-1:0] prio_o
);

  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;

  // new entry goes in front of this slot
  assign ins_o = !occupied_i || (prio_q > new_prio_i);

  always_comb begin
    tag_d  = tag_q;
    prio_d = prio_q;
    if (ctrl_i.push && ins_o) begin
      if (left_ins_i) begin
        tag_d  = left_tag_i;
        prio_d = left_prio_i;
      end else begin
        tag_d  = new_tag_i;
        prio_d = new_prio_i;
      end
    end else if (ctrl_i.pop) begin
      tag_d  = right_tag_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    prio_q <= prio_d;
  end

  assign tag_o  = tag_q;
  assign prio_o = prio_q;

endmodule

/* rtl/core/stable_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue kept sorted in a chain of cells; smallest priority
// leaves first, equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o with cmd_i (push or pop),
//   payload_i and priority_req_i. Every request gives one result on
//   out_valid_o/out_ready_i: status_o, out_payload_o, out_priority_o and
//   occupancy_o (entries held after the request).
//   A push compares the new entry with every cell at once and shifts the
//   cells behind the insert point one place back; a pop shifts all cells one
//   place forward and returns the head. Both finish in the cycle of
//   acceptance, so the result appears in the next cycle and one request can
//   be taken every cycle while no result is stalled.
//   A pop on an empty queue reports empty, a push on a full queue is dropped
//   and reports full; both return zero payload and priority.
//   The result sits in an output register; while it is stalled by the
//   receiver no new request is taken, and it is replaced in the cycle it
//   is taken, so back-to-back flow continues under a steady out_ready_i.
//   Reset empties the queue and clears the output valid.
// ----------------------------------------------------------------------------
module stable_priority_queue_core import spq_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int TAG_BITS  = 32,
  parameter int PRIO_BITS = 8,
  localparam int CntW     = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [TAG_BITS-1:0]  payload_i,
  input  logic [PRIO_BITS-1:0] priority_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [TAG_BITS-1:0]  out_payload_o,
  output logic [PRIO_BITS-1:0] out_priority_o,
  output logic [CntW-1:0]      occupancy_o
);

  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  logic                 accept;
  logic                 is_pop, full, empty;
  cell_ctrl_t           ctrl;
  logic [CntW-1:0]      count_q, count_d;
  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [TAG_BITS-1:0]  opay_q, opay_d;
  logic [PRIO_BITS-1:0] oprio_q, oprio_d;
  logic [CntW-1:0]      occ_q;

  logic [DEPTH-1:0]     ins;
  logic [TAG_BITS-1:0]  tags  [DEPTH];
  logic [PRIO_BITS-1:0] prios [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pop     = (cmd_i == CMD_POP);
  assign full       = (count_q == Full);
  assign empty      = (count_q == '0);
  assign ctrl.push  = accept && !is_pop && !full;
  assign ctrl.pop   = accept && is_pop && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    localparam int Lft = (i == 0) ? 0 : i - 1;
    localparam int Rgt = (i == DEPTH - 1) ? i : i + 1;
    spq_cell #(
      .TAG_BITS (TAG_BITS),
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk_i,
      .ctrl_i      (ctrl),
      .occupied_i  (Idx < count_q),
      .new_tag_i   (payload_i),
      .new_prio_i  (priority_req_i),
      .left_ins_i  ((i == 0) ? 1'b0 : ins[Lft]),
      .left_tag_i  (tags[Lft]),
      .left_prio_i (prios[Lft]),
      .right_tag_i (tags[Rgt]),
      .right_prio_i(prios[Rgt]),
      .ins_o       (ins[i]),
      .tag_o       (tags[i]),
      .prio_o      (prios[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    opay_d   = '0;
    oprio_d  = '0;
    if (is_pop) begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        opay_d  = tags[0];
        oprio_d = prios[0];
        count_d = count_q - CntW'(1);
      end
    end else begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      opay_q   <= opay_d;
      oprio_q  <= oprio_d;
      occ_q    <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_payload_o  = opay_q;
  assign out_priority_o = oprio_q;
  assign occupancy_o    = occ_q;

endmodule

/* rtl/core/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the stable sorted priority queue.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int TAG_BITS  = 32,
  parameter int PRIO_BITS = 8,
  localparam int CntW     = $clog2(DEPTH + 1)
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [1:0]           status_o,
  input logic [TAG_BITS-1:0]  out_payload_o,
  input logic [PRIO_BITS-1:0] out_priority_o,
  input logic [CntW-1:0]      occupancy_o
);

  // stalled result blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while result stalled");

  // accepted request shows a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("missing result");

  // failed command returns zero entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> out_payload_o == '0 && out_priority_o == '0)
    else $error("nonzero entry on failed command");

  // status code and occupancy in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != StatusInvalid && occupancy_o <= CntW'(DEPTH))
    else $error("bad status or occupancy");

  // full report only with a full queue, empty only with an empty one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != ST_FULL || occupancy_o == CntW'(DEPTH)) &&
                    (status_o != ST_EMPTY || occupancy_o == '0))
    else $error("status does not match occupancy");

endmodule

bind stable_priority_queue_core spq_checker #(
  .DEPTH    (DEPTH),
  .TAG_BITS (TAG_BITS),
  .PRIO_BITS(PRIO_BITS)
) u_spq_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .status_o,
  .out_payload_o,
  .out_priority_o,
  .occupancy_o
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks stable_priority_queue_core against a shadow sorted queue kept in the
// bench: every request (push or pop) is mirrored on acceptance and each result
// is compared field by field in order; both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int Depth      = 16;
  localparam int TagBits    = 32;
  localparam int PrioBits   = 8;
  localparam int CycleLimit = 400000;
  localparam int RandomReqs = 1800;

  typedef struct {
    cmd_e                cmd;
    logic [TagBits-1:0]  tag;
    logic [PrioBits-1:0] prio;
    int                  gap;
  } request_t;

  typedef struct {
    status_e             status;
    logic [TagBits-1:0]  tag;
    logic [PrioBits-1:0] prio;
    logic [4:0]          occupancy;
  } outcome_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                cmd_i          = 1'b0;
  logic [TagBits-1:0]  payload_i      = '0;
  logic [PrioBits-1:0] priority_req_i = '0;
  logic                out_ready_i    = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [1:0]          status_o;
  logic [TagBits-1:0]  out_payload_o;
  logic [PrioBits-1:0] out_priority_o;
  logic [4:0]          occupancy_o;

  request_t            request_q[$];
  outcome_t            outcome_q[$];
  logic [TagBits-1:0]  held_tag[Depth];
  logic [PrioBits-1:0] held_prio[Depth];
  int                  held_count   = 0;
  int                  idle_left    = 0;
  int                  mismatches   = 0;
  int                  results_seen = 0;
  int                  cycle_count  = 0;
  logic                hold_active  = 1'b0;

  stable_priority_queue_core #(
    .DEPTH     (Depth),
    .TAG_BITS  (TagBits),
    .PRIO_BITS (PrioBits)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .payload_i      (payload_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_payload_o  (out_payload_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int send_gap(input bit calm);
    if (calm || $urandom_range(0, 99) < 60) return 0;
    return idle_length();
  endfunction

  task automatic add_request(input cmd_e cmd, input logic [TagBits-1:0] tag,
                             input logic [PrioBits-1:0] prio, input int gap);
    request_t r;
    r.cmd  = cmd;
    r.tag  = tag;
    r.prio = prio;
    r.gap  = gap;
    request_q.push_back(r);
  endtask

  // mirror of the sorted store: insert behind equal priorities, pop the head
  task automatic shadow_queue_step(input cmd_e cmd, input logic [TagBits-1:0] tag,
                                   input logic [PrioBits-1:0] prio);
    outcome_t o;
    int       pos;
    o.status = ST_OK;
    o.tag    = '0;
    o.prio   = '0;
    if (cmd == CMD_PUSH) begin
      if (held_count >= Depth) begin
        o.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] <= prio) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_tag[i]  = held_tag[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_tag[pos]  = tag;
        held_prio[pos] = prio;
        held_count++;
      end
    end else if (held_count == 0) begin
      o.status = ST_EMPTY;
    end else begin
      o.tag  = held_tag[0];
      o.prio = held_prio[0];
      for (int i = 1; i < held_count; i++) begin
        held_tag[i-1]  = held_tag[i];
        held_prio[i-1] = held_prio[i];
      end
      held_count--;
    end
    o.occupancy = 5'(held_count);
    outcome_q.push_back(o);
  endtask

  task automatic check_field(input string name, input logic [TagBits-1:0] want,
                             input logic [TagBits-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : driver_proc
    request_t req;
    logic     offering;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_left = 0;
    end else begin
      offering = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        shadow_queue_step(cmd_e'(cmd_i), payload_i, priority_req_i);
        offering = 1'b0;
      end
      if (!offering) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          cmd_i          <= req.cmd;
          payload_i      <= req.tag;
          priority_req_i <= req.prio;
          idle_left = req.gap;
          offering = 1'b1;
        end
      end
      in_valid_i <= offering;
    end
  end

  // result receiver with random stalls
  always @(posedge clk_i or negedge rst_ni) begin : sink_proc
    int stall_left;
    int mode_left;
    bit calm;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      mode_left  = 0;
      calm       = 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        calm = ($urandom_range(0, 2) == 0);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 99) < 15) stall_left = idle_length();
      out_ready_i <= (stall_left == 0) && !hold_active;
    end
  end

  // long receiver hold-offs so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin : hold_proc
    int hold_left;
    int holds_done;
    if (!rst_ni) begin
      hold_active <= 1'b0;
      hold_left  = 0;
      holds_done = 0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_done < 2 && results_seen >= (holds_done + 1) * 600) begin
        hold_left = 300;
        holds_done++;
      end
      hold_active <= (hold_left > 0);
    end
  end

  // result monitor
  always @(posedge clk_i) begin : monitor_proc
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected nothing, actual status %0d",
                 $time, status_o);
      end else begin
        want = outcome_q.pop_front();
        check_field("status", TagBits'(want.status), TagBits'(status_o));
        check_field("payload", want.tag, out_payload_o);
        check_field("priority", TagBits'(want.prio), TagBits'(out_priority_o));
        check_field("occupancy", TagBits'(want.occupancy), TagBits'(occupancy_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog_proc
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int         total;
    int         burst;
    int         pop_pct;
    int         prio_mode;
    bit         calm;
    cmd_e       c;
    logic [7:0] p;

    // directed: empty pop, extremes, equal priorities, fill to full
    add_request(CMD_POP, 32'hFFFF_FFFF, 8'hFF, send_gap(1'b0));
    add_request(CMD_PUSH, 32'h0000_0000, 8'h00, send_gap(1'b0));
    add_request(CMD_PUSH, 32'hFFFF_FFFF, 8'hFF, send_gap(1'b0));
    add_request(CMD_PUSH, 32'h0000_0001, 8'h00, send_gap(1'b0));
    repeat (4) add_request(CMD_POP, 32'h0, 8'h0, send_gap(1'b0));
    for (int k = 0; k < Depth; k++)
      add_request(CMD_PUSH, $urandom, 8'((k * 37) % 7 * 40 + (k == 5 ? 15 : 0)),
                  send_gap(1'b1));
    add_request(CMD_PUSH, 32'hA5A5_A5A5, 8'h01, send_gap(1'b0));

    // random bursts with shifting push/pop balance and priority spread
    total = 0;
    while (total < RandomReqs) begin
      burst = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0:       pop_pct = 20;
        1:       pop_pct = 80;
        default: pop_pct = 50;
      endcase
      prio_mode = $urandom_range(0, 2);
      calm = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        c = ($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_PUSH;
        case (prio_mode)
          0:       p = 8'($urandom_range(0, 3));
          1:       p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: p = 8'($urandom);
        endcase
        add_request(c, $urandom, p, send_gap(calm));
        total++;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
